FILE: design/ttv_pkg.sv
// Shared types and constants for the triangle tangent vector core.
// Used by ttv_ctrl, ttv_dp and triangle_tangent_vector_core; no dependencies.
package ttv_pkg;

	// Default parameter values
	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed widths
	localparam int OUT_BITS   = 18;
	localparam int THR_BITS   = 16;
	localparam int ADDR_W     = 3;
	localparam int CNT_W      = 6;
	localparam int MUL_W      = 31;
	localparam int SQ_W       = 63;
	localparam int SQRT_STEPS = 32;

	localparam logic [THR_BITS-1:0] THR_RESET = 16'd1074;

	// Word index of the threshold register
	localparam logic REG_DET_THR = 1'b0;

	// Vector being normalized
	typedef enum logic [2:0] {
		OP_E1,
		OP_E2,
		OP_TA,
		OP_TB,
		OP_TN
	} op_t;

	// Datapath micro-operations
	typedef enum logic [4:0] {
		UOP_NONE,
		UOP_CAP0,
		UOP_CAP1,
		UOP_CAP2,
		UOP_LOAD,
		UOP_SHR,
		UOP_SHL,
		UOP_SQ,
		UOP_SQRT_INIT,
		UOP_SQRT,
		UOP_DIV_INIT,
		UOP_DIV,
		UOP_STORE,
		UOP_STORE_ZERO,
		UOP_DET,
		UOP_TV,
		UOP_FALLBACK
	} uop_t;

	typedef struct packed {
		uop_t       uop;
		op_t        op;
		logic [2:0] step;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic high;
		logic low;
		logic det_small;
		logic out_busy;
	} stat_t;

endpackage

FILE: design/triangle_tangent_vector_core.sv
// Per-triangle unit tangent core: top level with the threshold register port.
// Depends on ttv_pkg, ttv_ctrl and ttv_dp.
//
// Vertices arrive one beat at a time; the first two beats of a triangle are
// stored, and the third starts the computation and gives one result beat.
// After the third vertex is accepted, in_stall stays high until the result is
// written. Each normalization scales its vector by single-bit steps until its
// largest component lies in [2^29, 2^30); a zero-length vector skips the
// square root and division and is stored as zero. A triangle that falls back
// to (1,0,0) skips the tangent stages and takes four normalizations. The work
// is done by the one shared normalizer: a 32-step bitwise square root and a
// FRAC_BITS+1 step divider that runs all three components side by side, plus
// one multiplier used for the sums of squares, the determinant and the tangent.
// A result still waiting on out_stall holds the next triangle at its final
// store, or at the threshold check for a fallback, until the slot frees. The
// next triangle's first vertices are taken while a finished result waits on
// out_stall.
module triangle_tangent_vector_core #(
	parameter int COORD_BITS = ttv_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = ttv_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// vertex channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        pos_x,
	input  logic signed [COORD_BITS-1:0]        pos_y,
	input  logic signed [COORD_BITS-1:0]        pos_z,
	input  logic signed [COORD_BITS-1:0]        tex_u,
	input  logic signed [COORD_BITS-1:0]        tex_v,
	// tangent channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ttv_pkg::OUT_BITS-1:0] tangent_x,
	output logic signed [ttv_pkg::OUT_BITS-1:0] tangent_y,
	output logic signed [ttv_pkg::OUT_BITS-1:0] tangent_z,
	output logic                                degenerate,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ttv_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import ttv_pkg::*;

	logic [THR_BITS-1:0] det_thr_q;
	logic                reg_wr;
	cmd_t                cmd;
	stat_t               stat;

	// Threshold register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DET_THR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			det_thr_q <= THR_RESET;
		else if (reg_wr)
			det_thr_q <= pwdata[THR_BITS-1:0];
	end

	assign prdata = (paddr[2] == REG_DET_THR) ? 32'(det_thr_q) : '0;

	ttv_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	ttv_dp #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.det_threshold(det_thr_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tangent_x    (tangent_x),
		.tangent_y    (tangent_y),
		.tangent_z    (tangent_z),
		.degenerate   (degenerate)
	);

endmodule

FILE: design/ttv_ctrl.sv
// Sequencer for the triangle tangent vector core.
// Depends on ttv_pkg; drives the micro-operations of ttv_dp.
module ttv_ctrl #(
	parameter int FRAC_BITS = ttv_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ttv_pkg::stat_t stat,
	output ttv_pkg::cmd_t  cmd
);
	import ttv_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_SHIFT,
		S_SQ,
		S_SQRT_INIT,
		S_SQRT,
		S_DIV_INIT,
		S_DIV,
		S_STORE,
		S_DET,
		S_THRESH,
		S_TV
	} state_t;

	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(FRAC_BITS);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	op_t              op_q;
	logic [1:0]       vcnt_q;
	logic             zero_q;
	logic             out_block;

	// Result slot must be free before the last store
	assign out_block = stat.out_busy;
	assign in_stall  = (state_q != S_IDLE);

	// Command decode
	always_comb begin
		cmd.uop  = UOP_NONE;
		cmd.op   = op_q;
		cmd.step = cnt_q[2:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (vcnt_q)
						2'd1:    cmd.uop = UOP_CAP1;
						2'd2:    cmd.uop = UOP_CAP2;
						default: cmd.uop = UOP_CAP0;
					endcase
				end
			end
			S_LOAD:      cmd.uop = UOP_LOAD;
			S_SHIFT: begin
				if (!stat.zero && stat.high)
					cmd.uop = UOP_SHR;
				else if (!stat.zero && stat.low)
					cmd.uop = UOP_SHL;
			end
			S_SQ:        cmd.uop = UOP_SQ;
			S_SQRT_INIT: cmd.uop = UOP_SQRT_INIT;
			S_SQRT:      cmd.uop = UOP_SQRT;
			S_DIV_INIT:  cmd.uop = UOP_DIV_INIT;
			S_DIV:       cmd.uop = UOP_DIV;
			S_STORE: begin
				if (!(op_q == OP_TN && out_block))
					cmd.uop = zero_q ? UOP_STORE_ZERO : UOP_STORE;
			end
			S_DET:       cmd.uop = UOP_DET;
			S_THRESH: begin
				if (stat.det_small && !out_block)
					cmd.uop = UOP_FALLBACK;
			end
			S_TV:        cmd.uop = UOP_TV;
			default:     cmd.uop = UOP_NONE;
		endcase
	end

	// State, counters and vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			op_q    <= OP_E1;
			vcnt_q  <= 2'd0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (vcnt_q)
							2'd1: vcnt_q <= 2'd2;
							2'd2: begin
								vcnt_q  <= 2'd0;
								op_q    <= OP_E1;
								state_q <= S_LOAD;
							end
							default: vcnt_q <= 2'd1;
						endcase
					end
				end
				S_LOAD: state_q <= S_SHIFT;
				S_SHIFT: begin
					if (stat.zero) begin
						zero_q  <= 1'b1;
						state_q <= S_STORE;
					end else if (!stat.high && !stat.low) begin
						zero_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == CNT_W'(3))
						state_q <= S_SQRT_INIT;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == SQRT_LAST)
						state_q <= S_DIV_INIT;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST)
						state_q <= S_STORE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_STORE: begin
					if (!(op_q == OP_TN && out_block)) begin
						unique case (op_q)
							OP_E1: begin
								op_q    <= OP_E2;
								state_q <= S_LOAD;
							end
							OP_E2: begin
								op_q    <= OP_TA;
								state_q <= S_LOAD;
							end
							OP_TA: begin
								op_q    <= OP_TB;
								state_q <= S_LOAD;
							end
							OP_TB: begin
								cnt_q   <= '0;
								state_q <= S_DET;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DET: begin
					if (cnt_q == CNT_W'(2))
						state_q <= S_THRESH;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_THRESH: begin
					if (stat.det_small) begin
						if (!out_block)
							state_q <= S_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= S_TV;
					end
				end
				S_TV: begin
					if (cnt_q == CNT_W'(6)) begin
						op_q    <= OP_TN;
						state_q <= S_LOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/ttv_dp.sv
// Datapath of the triangle tangent vector core: vertex store, shared
// normalizer (scale, sum of squares, bitwise square root, divider), determinant,
// tangent and result registers. Depends on ttv_pkg; sequenced by ttv_ctrl.
module ttv_dp #(
	parameter int COORD_BITS = ttv_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = ttv_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ttv_pkg::cmd_t                         cmd,
	output ttv_pkg::stat_t                        stat,
	input  logic signed [COORD_BITS-1:0]          pos_x,
	input  logic signed [COORD_BITS-1:0]          pos_y,
	input  logic signed [COORD_BITS-1:0]          pos_z,
	input  logic signed [COORD_BITS-1:0]          tex_u,
	input  logic signed [COORD_BITS-1:0]          tex_v,
	input  logic [ttv_pkg::THR_BITS-1:0]          det_threshold,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ttv_pkg::OUT_BITS-1:0]   tangent_x,
	output logic signed [ttv_pkg::OUT_BITS-1:0]   tangent_y,
	output logic signed [ttv_pkg::OUT_BITS-1:0]   tangent_z,
	output logic                                  degenerate
);
	import ttv_pkg::*;

	localparam int W    = (COORD_BITS + 1 > 2 * FRAC_BITS + 3) ?
		COORD_BITS + 1 : 2 * FRAC_BITS + 3;
	localparam int NW   = FRAC_BITS + 2;
	localparam int QW   = FRAC_BITS + 1;
	localparam int DETW = 2 * FRAC_BITS + 3;
	localparam int SH_L = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
	localparam int SH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
	localparam int DW   = DETW + SH_L;
	localparam logic [NW-1:0] ONE_Q = NW'(1) << FRAC_BITS;

	// Vertex store: slots 0 and 1 hold the first two vertices, slot 2 the third
	logic signed [COORD_BITS-1:0] vp_q [3][3];
	logic signed [COORD_BITS-1:0] vt_q [3][2];

	// Normalizer state
	logic [W-1:0]                 mag_q [3];
	logic [2:0]                   neg_q;
	logic [SQ_W-1:0]              sum_q, x_q, res_q, bit_q;
	logic [31:0]                  r_q;
	logic [31:0]                  rem_q [3];
	logic [QW-1:0]                quo_q [3];
	logic signed [2*MUL_W-1:0]    prod_q;

	// Normalized edges and intermediate vectors
	logic signed [NW-1:0]         e1_q [3];
	logic signed [NW-1:0]         e2_q [3];
	logic signed [NW-1:0]         ta_q [2];
	logic signed [NW-1:0]         tb_q [2];
	logic signed [DETW-1:0]       det_q;
	logic signed [DETW-1:0]       tv_q [3];

	logic                         out_valid_q;
	logic signed [OUT_BITS-1:0]   tx_q, ty_q, tz_q;
	logic                         degenerate_q;

	logic signed [W-1:0]          src [3];
	logic [W-1:0]                 src_abs [3];
	logic [2:0]                   src_neg;
	logic signed [MUL_W-1:0]      ma, mb;
	logic [1:0]                   sq_k, tv_k, acc_k;
	logic [2:0]                   step_m1;
	logic [SQ_W-1:0]              trial;
	logic                         sq_ge;
	logic [2:0]                   div_ge;
	logic [31:0]                  rem_sub [3];
	logic signed [NW-1:0]         store_val [3];
	logic [DETW-1:0]              abs_det;
	logic [DW-1:0]                det30;

	// Vector to normalize
	always_comb begin
		for (int i = 0; i < 3; i++)
			src[i] = '0;
		unique case (cmd.op)
			OP_E1: for (int i = 0; i < 3; i++)
				src[i] = W'(vp_q[1][i]) - W'(vp_q[0][i]);
			OP_E2: for (int i = 0; i < 3; i++)
				src[i] = W'(vp_q[2][i]) - W'(vp_q[0][i]);
			OP_TA: for (int i = 0; i < 2; i++)
				src[i] = W'(vt_q[1][i]) - W'(vt_q[0][i]);
			OP_TB: for (int i = 0; i < 2; i++)
				src[i] = W'(vt_q[2][i]) - W'(vt_q[0][i]);
			OP_TN: for (int i = 0; i < 3; i++)
				src[i] = W'(tv_q[i]);
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			src_abs[i] = src[i][W-1] ? W'(-src[i]) : W'(src[i]);
			src_neg[i] = src[i][W-1] ^ (cmd.op == OP_TN && det_q[DETW-1]);
		end
	end

	// Threshold compare in Q2.30
	assign abs_det = det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
	assign det30   = (DW'(abs_det) << SH_L) >> SH_R;

	// Status: range of the magnitudes, threshold, result slot
	always_comb begin
		stat.zero = 1'b1;
		stat.high = 1'b0;
		stat.low  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i] != '0)
				stat.zero = 1'b0;
			if (|mag_q[i][W-1:30])
				stat.high = 1'b1;
			if (|mag_q[i][W-1:29])
				stat.low = 1'b0;
		end
		stat.det_small = det30 < DW'(det_threshold);
		stat.out_busy  = out_valid_q;
	end

	// Shared multiplier operands
	assign sq_k    = (cmd.step[1:0] == 2'd3) ? 2'd2 : cmd.step[1:0];
	assign tv_k    = (cmd.step[2:1] == 2'd3) ? 2'd2 : cmd.step[2:1];
	assign step_m1 = cmd.step - 3'd1;
	assign acc_k   = (step_m1[2:1] == 2'd3) ? 2'd2 : step_m1[2:1];

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.uop)
			UOP_SQ: begin
				ma = MUL_W'({1'b0, mag_q[sq_k][29:0]});
				mb = MUL_W'({1'b0, mag_q[sq_k][29:0]});
			end
			UOP_DET: begin
				if (cmd.step == 3'd0) begin
					ma = MUL_W'(ta_q[0]);
					mb = MUL_W'(tb_q[1]);
				end else begin
					ma = MUL_W'(ta_q[1]);
					mb = MUL_W'(tb_q[0]);
				end
			end
			UOP_TV: begin
				if (!cmd.step[0]) begin
					ma = MUL_W'(tb_q[1]);
					mb = MUL_W'(e1_q[tv_k]);
				end else begin
					ma = MUL_W'(ta_q[1]);
					mb = MUL_W'(e2_q[tv_k]);
				end
			end
			default: ;
		endcase
	end

	// Square root digit and divider steps
	assign trial = res_q + bit_q;
	assign sq_ge = x_q >= trial;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_ge[i]    = rem_q[i] >= r_q;
			rem_sub[i]   = div_ge[i] ? rem_q[i] - r_q : rem_q[i];
			store_val[i] = neg_q[i] ? -signed'({1'b0, quo_q[i]}) :
				signed'({1'b0, quo_q[i]});
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.uop)
			UOP_CAP0, UOP_CAP1, UOP_CAP2: begin
				for (int s = 0; s < 3; s++) begin
					if ((s == 0 && cmd.uop == UOP_CAP0) ||
						(s == 1 && cmd.uop == UOP_CAP1) ||
						(s == 2 && cmd.uop == UOP_CAP2)) begin
						vp_q[s][0] <= pos_x;
						vp_q[s][1] <= pos_y;
						vp_q[s][2] <= pos_z;
						vt_q[s][0] <= tex_u;
						vt_q[s][1] <= tex_v;
					end
				end
			end
			UOP_LOAD: begin
				for (int i = 0; i < 3; i++)
					mag_q[i] <= src_abs[i];
				neg_q <= src_neg;
				sum_q <= '0;
			end
			UOP_SHR: for (int i = 0; i < 3; i++)
				mag_q[i] <= mag_q[i] >> 1;
			UOP_SHL: for (int i = 0; i < 3; i++)
				mag_q[i] <= mag_q[i] << 1;
			UOP_SQ: begin
				if (cmd.step != 3'd3)
					prod_q <= ma * mb;
				if (cmd.step != 3'd0)
					sum_q <= sum_q + SQ_W'(prod_q[59:0]);
			end
			UOP_SQRT_INIT: begin
				x_q   <= sum_q;
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 1);
			end
			UOP_SQRT: begin
				if (sq_ge) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			UOP_DIV_INIT: begin
				r_q <= res_q[31:0];
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= 32'(mag_q[i][29:0]);
					quo_q[i] <= '0;
				end
			end
			UOP_DIV: for (int i = 0; i < 3; i++) begin
				quo_q[i] <= {quo_q[i][QW-2:0], div_ge[i]};
				rem_q[i] <= rem_sub[i] << 1;
			end
			UOP_STORE, UOP_STORE_ZERO: begin
				unique case (cmd.op)
					OP_E1: for (int i = 0; i < 3; i++)
						e1_q[i] <= (cmd.uop == UOP_STORE) ? store_val[i] : '0;
					OP_E2: for (int i = 0; i < 3; i++)
						e2_q[i] <= (cmd.uop == UOP_STORE) ? store_val[i] : '0;
					OP_TA: for (int i = 0; i < 2; i++)
						ta_q[i] <= (cmd.uop == UOP_STORE) ? store_val[i] : '0;
					OP_TB: for (int i = 0; i < 2; i++)
						tb_q[i] <= (cmd.uop == UOP_STORE) ? store_val[i] : '0;
					OP_TN: begin
						tx_q <= (cmd.uop == UOP_STORE) ? OUT_BITS'(store_val[0]) : '0;
						ty_q <= (cmd.uop == UOP_STORE) ? OUT_BITS'(store_val[1]) : '0;
						tz_q <= (cmd.uop == UOP_STORE) ? OUT_BITS'(store_val[2]) : '0;
						degenerate_q <= 1'b0;
					end
					default: ;
				endcase
			end
			UOP_DET: begin
				if (cmd.step != 3'd2)
					prod_q <= ma * mb;
				if (cmd.step == 3'd1)
					det_q <= DETW'(prod_q);
				else if (cmd.step == 3'd2)
					det_q <= det_q - DETW'(prod_q);
			end
			UOP_TV: begin
				if (cmd.step != 3'd6)
					prod_q <= ma * mb;
				if (cmd.step != 3'd0)
					tv_q[acc_k] <= step_m1[0] ? tv_q[acc_k] - DETW'(prod_q) :
						DETW'(prod_q);
			end
			UOP_FALLBACK: begin
				tx_q         <= OUT_BITS'(signed'(ONE_Q));
				ty_q         <= '0;
				tz_q         <= '0;
				degenerate_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.uop == UOP_FALLBACK ||
				((cmd.uop == UOP_STORE || cmd.uop == UOP_STORE_ZERO) && cmd.op == OP_TN))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign tangent_x  = tx_q;
	assign tangent_y  = ty_q;
	assign tangent_z  = tz_q;
	assign degenerate = degenerate_q;

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == UOP_DIV |-> r_q != '0)
		else $error("divisor is zero during division");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == UOP_DIV |-> {1'b0, rem_q[0]} < {r_q, 1'b0})
		else $error("divider remainder out of range");

	a_fallback_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && degenerate_q |-> ty_q == '0 && tz_q == '0)
		else $error("fallback tangent is not along x");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.uop == UOP_FALLBACK ||
		((cmd.uop == UOP_STORE || cmd.uop == UOP_STORE_ZERO) && cmd.op == OP_TN))
		|-> !out_valid_q)
		else $error("result written while previous beat pending");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_tangent_vector_core: vertex beats in, unit tangents out.
// Depends on ttv_pkg and the core; carries its own fixed-point tangent predictor.
module tb;
	import ttv_pkg::*;

	localparam int CB = 32;
	localparam int FB = 16;

	typedef struct {
		logic signed [OUT_BITS-1:0] tx, ty, tz;
		logic deg;
	} tangent_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [CB-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;
	logic signed [OUT_BITS-1:0] tangent_x, tangent_y, tangent_z;
	logic degenerate;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	triangle_tangent_vector_core DUT (.*);

	tangent_t tangent_q[$];
	int errors = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_recv = 0;

	// predictor state
	logic [15:0] thr_model;
	logic signed [CB-1:0] held_vtx[2][5];
	int held_cnt;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void norm_vec(input longint v[3], input int n, output longint o[3]);
		longint unsigned mg[3], m, s, r, res, bt, x;
		m = 0;
		s = 0;
		for (int i = 0; i < n; i++) begin
			mg[i] = v[i] < 0 ? -v[i] : v[i];
			if (mg[i] > m) m = mg[i];
		end
		if (m == 0) begin
			for (int i = 0; i < 3; i++) o[i] = 0;
			return;
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < n; i++) mg[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < n; i++) mg[i] <<= 1;
		end
		for (int i = 0; i < n; i++) s += mg[i] * mg[i];
		// bitwise integer square root
		x = s;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= res + bt) begin
				x -= res + bt;
				res = (res >> 1) + bt;
			end else res >>= 1;
			bt >>= 2;
		end
		r = res;
		for (int i = 0; i < 3; i++) o[i] = 0;
		for (int i = 0; i < n; i++) begin
			o[i] = longint'((mg[i] << FB) / r);
			if (v[i] < 0) o[i] = -o[i];
		end
	endfunction

	// Compute the tangent for a completed triangle and queue it.
	function automatic void predict_tangent(input logic signed [CB-1:0] vin[5]);
		longint d1[3], d2[3], e1[3], e2[3], ta[3], tb[3], tv[3], tn[3], det;
		longint unsigned ad;
		tangent_t t;
		for (int i = 0; i < 3; i++) begin
			d1[i] = longint'(held_vtx[1][i]) - longint'(held_vtx[0][i]);
			d2[i] = longint'(vin[i]) - longint'(held_vtx[0][i]);
		end
		norm_vec(d1, 3, e1);
		norm_vec(d2, 3, e2);
		for (int i = 0; i < 3; i++) begin
			d1[i] = i < 2 ? longint'(held_vtx[1][3+i]) - longint'(held_vtx[0][3+i]) : 0;
			d2[i] = i < 2 ? longint'(vin[3+i]) - longint'(held_vtx[0][3+i]) : 0;
		end
		norm_vec(d1, 2, ta);
		norm_vec(d2, 2, tb);
		det = ta[0] * tb[1] - ta[1] * tb[0];
		ad = det < 0 ? -det : det;
		ad = ad >> (2 * FB - 30);
		if (ad < thr_model) begin
			t.tx = OUT_BITS'(1 << FB);
			t.ty = '0;
			t.tz = '0;
			t.deg = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				tv[i] = tb[1] * e1[i] - ta[1] * e2[i];
				if (det < 0) tv[i] = -tv[i];
			end
			norm_vec(tv, 3, tn);
			t.tx = OUT_BITS'(tn[0]);
			t.ty = OUT_BITS'(tn[1]);
			t.tz = OUT_BITS'(tn[2]);
			t.deg = 1'b0;
		end
		tangent_q.push_back(t);
	endfunction

	// Send one vertex beat and update the predictor on acceptance.
	// Valid stays high after the beat; an idle point in the next send or wait_drained drops it.
	task automatic send_vertex(input logic signed [CB-1:0] v[5]);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		{pos_x, pos_y, pos_z, tex_u, tex_v} <= {v[0], v[1], v[2], v[3], v[4]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (held_cnt == 2) begin
			predict_tangent(v);
			held_cnt = 0;
		end else begin
			held_vtx[held_cnt] = v;
			held_cnt++;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 0;
		while (tangent_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] val);
		wait_drained();
		psel <= 1;
		pwrite <= 1;
		paddr <= ADDR_W'(REG_DET_THR) << 2;
		pwdata <= {$urandom} & 32'hFFFF_0000 | val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		thr_model = val;
	endtask

	function automatic logic signed [CB-1:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed(CB'($urandom_range(2000))) - 1000;
			2: return $signed(CB'($urandom_range(1 << 20))) - (1 << 19);
			default: return $signed(CB'($urandom_range(32'h3FFF_FFFF))) - 32'sh2000_0000;
		endcase
	endfunction

	task automatic send_triangle(input int mode);
		logic signed [CB-1:0] v[5];
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 5; i++) v[i] = rand_coord(mode);
			send_vertex(v);
		end
	endtask

	// Extremes, fallback, zero-length edges, parallel edges.
	task automatic test_directed();
		logic signed [CB-1:0] v[5];
		v = '{0, 0, 0, 0, 0}; send_vertex(v);
		v = '{65536, 0, 0, 65536, 0}; send_vertex(v);
		v = '{0, 65536, 0, 0, 65536}; send_vertex(v);
		// all at one point: zero-length edges, fallback
		v = '{5, 5, 5, 5, 5}; send_vertex(v); send_vertex(v); send_vertex(v);
		// full-scale extremes
		v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
		send_vertex(v);
		v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
		send_vertex(v);
		v = '{-1, -1, -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}; send_vertex(v);
		// parallel position edges, good texture
		v = '{0, 0, 0, 0, 0}; send_vertex(v);
		v = '{100, 200, 300, 65536, 0}; send_vertex(v);
		v = '{200, 400, 600, 0, 65536}; send_vertex(v);
		// collinear texture coordinates
		v = '{0, 0, 0, 0, 0}; send_vertex(v);
		v = '{9, 1, 2, 3, 3}; send_vertex(v);
		v = '{1, 9, 4, 7, 7}; send_vertex(v);
		// negative determinant
		v = '{1, 2, 3, 0, 0}; send_vertex(v);
		v = '{-70000, 5, 9, 0, 65536}; send_vertex(v);
		v = '{4, 80000, -3, 65536, 0}; send_vertex(v);
		wait_drained();
	endtask

	task automatic test_random(input int tris);
		for (int n = 0; n < tris; n++) begin
			if ($urandom_range(19) == 0) begin
				// isolated noise vertex shifts the triangle phase
				logic signed [CB-1:0] v[5];
				for (int i = 0; i < 5; i++) v[i] = rand_coord(0);
				send_vertex(v);
			end
			send_triangle($urandom_range(3));
		end
	endtask

	// Receiver holds off while the sender keeps offering, then sender pauses to drain.
	task automatic test_backpressure();
		hold_recv = 1;
		send_triangle(3);
		send_triangle(2);
		send_triangle(1);
		hold_recv = 0;
		wait_drained();
	endtask

	task automatic test_thresholds();
		write_threshold(16'hFFFF);
		test_random(20);
		write_threshold(16'd0);
		test_random(20);
		write_threshold(16'd30000);
		test_random(20);
		write_threshold(THR_RESET);
	endtask

	// Receiver stall generator.
	initial begin
		int hold_cycles;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_recv) begin
				out_stall <= 1;
				hold_cycles = 0;
				while (hold_cycles < 400) begin
					@(negedge clk);
					hold_cycles++;
				end
				out_stall <= 0;
				wait (!hold_recv);
			end else out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		tangent_t exp_t;
		if (arst_n && out_valid && !out_stall) begin
			if (tangent_q.size() == 0) begin
				$display("%0t: unexpected tangent beat %0d %0d %0d deg=%0b", $time,
					tangent_x, tangent_y, tangent_z, degenerate);
				errors++;
			end else begin
				exp_t = tangent_q.pop_front();
				if (tangent_x !== exp_t.tx || tangent_y !== exp_t.ty ||
				    tangent_z !== exp_t.tz || degenerate !== exp_t.deg) begin
					$display("%0t: expected %0d %0d %0d deg=%0b, got %0d %0d %0d deg=%0b",
						$time, exp_t.tx, exp_t.ty, exp_t.tz, exp_t.deg,
						tangent_x, tangent_y, tangent_z, degenerate);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		{pos_x, pos_y, pos_z, tex_u, tex_v} = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		thr_model = THR_RESET;
		held_cnt = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_thresholds();
		test_backpressure();
		send_idle_pct = 0; recv_stall_pct = 0; test_random(60);
		send_idle_pct = 53; recv_stall_pct = 0; test_random(60);
		send_idle_pct = 0; recv_stall_pct = 53; test_random(60);
		send_idle_pct = 38; recv_stall_pct = 38; test_random(60);
		send_idle_pct = 0; recv_stall_pct = 0;
		wait_drained();
		repeat (400) @(negedge clk);
		if (errors == 0 && tangent_q.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule

FILE: triangle_tangent_vector_core.f
design/ttv_pkg.sv
design/ttv_ctrl.sv
design/ttv_dp.sv
design/triangle_tangent_vector_core.sv
tb/tb.sv
